### hw/rtl/calendar_date_decrement_core_assert.svh
// ---------------------------------------------------------------------------
// Calendar date decrement core assertion macros
// Clocked, reset-qualified assertion wrappers. Define NO_ASSERTIONS to drop them.
// ---------------------------------------------------------------------------
`ifndef CALENDAR_DATE_DECREMENT_CORE_ASSERT_SVH
`define CALENDAR_DATE_DECREMENT_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define CDD_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("calendar_date_decrement_core: assertion failed");
// Condition in one cycle that implies another condition in the next cycle.
`define CDD_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("calendar_date_decrement_core: sequence assertion failed");
`else
`define CDD_ASSERT(label, prop)
`define CDD_ASSERT_NEXT(label, pre, post)
`endif
`endif

### hw/rtl/cdd_pkg.sv
// ---------------------------------------------------------------------------
// Calendar date decrement package
// Request kinds, status codes, reset date and Gregorian calendar helpers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cdd_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned AmtW   = 14;
  localparam int unsigned KindW  = 3;
  localparam int unsigned StatW  = 2;

  // Request kinds.
  localparam logic [KindW-1:0] KIND_LOAD   = 3'd0;
  localparam logic [KindW-1:0] KIND_DAYS   = 3'd1;
  localparam logic [KindW-1:0] KIND_WEEKS  = 3'd2;
  localparam logic [KindW-1:0] KIND_MONTHS = 3'd3;
  localparam logic [KindW-1:0] KIND_YEARS  = 3'd4;

  // Result status codes.
  localparam logic [StatW-1:0] STAT_DONE    = 2'd0;
  localparam logic [StatW-1:0] STAT_UNDER   = 2'd1;
  localparam logic [StatW-1:0] STAT_BADLOAD = 2'd2;

  // Date after reset.
  localparam logic [DayW-1:0]   RESET_DAY   = 5'd11;
  localparam logic [MonthW-1:0] RESET_MONTH = 4'd5;
  localparam logic [YearW-1:0]  RESET_YEAR  = 14'd2024;

  localparam logic [YearW-1:0] YEAR_MAX = 14'd9999;

  // Division by 100 through a reciprocal: floor(x / 100) = (x * 5243) >> 19
  // holds exactly for every 14-bit x.
  localparam logic [12:0]  RECIP100    = 13'd5243;
  localparam int unsigned  RecipShift  = 19;
  localparam int unsigned  ProdW       = YearW + 13;
  localparam int unsigned  CentW       = 8;
  localparam int unsigned  YyW         = 7;

  // Leap year from the century and the year within the century.
  function automatic logic is_leap(input logic [CentW-1:0] cent, input logic [YyW-1:0] yy);
    logic leap;
    if (yy == '0) begin
      leap = (cent[1:0] == 2'd0);
    end else begin
      leap = (yy[1:0] == 2'd0);
    end
    return leap;
  endfunction

  // Length of a month; zero for a month number outside 1 to 12.
  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] month,
                                                 input logic leap);
    logic [DayW-1:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

### hw/rtl/calendar_date_decrement_core.sv
// ---------------------------------------------------------------------------
// Calendar date decrement core: loads a date, or steps the held date back by days, weeks,
// months or years; a year request that reaches past year 0 is refused at once.
// One request at a time, no overlap.
// Reset (asynchronous, active low) sets the date to 11 May 2024; done_o cannot be stalled.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "calendar_date_decrement_core_assert.svh"

module calendar_date_decrement_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [cdd_pkg::KindW-1:0]    kind_i,
  input  logic [cdd_pkg::AmtW-1:0]     amount_i,
  input  logic [cdd_pkg::DayW-1:0]     load_day_i,
  input  logic [cdd_pkg::MonthW-1:0]   load_month_i,
  input  logic [cdd_pkg::YearW-1:0]    load_year_i,
  output logic                         done_o,
  output logic [cdd_pkg::DayW-1:0]     out_day_o,
  output logic [cdd_pkg::MonthW-1:0]   out_month_o,
  output logic [cdd_pkg::YearW-1:0]    out_year_o,
  output logic [cdd_pkg::StatW-1:0]    status_o
);

  import cdd_pkg::*;

  // The datapath works on the year split into century and year-in-century.
  // With that split, stepping back across a January is a pair of small
  // decrements, and the 4/100/400 leap rule is a look at two low bits.
  // The split itself is the one shared arithmetic unit: a reciprocal
  // multiply (registered) followed by the remainder in the next cycle.
  // Each request runs on a working copy of the date, which is written back
  // to the held date only when the request completes without refusal, so an
  // underflow is simply detected as "a borrow is needed in January of year 0".

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_REM,
    S_LOAD,
    S_DAYS,
    S_MONS,
    S_YEARS,
    S_FIN
  } state_e;

  localparam int unsigned RemW = AmtW + 3;   // room for a week count times seven

  state_e              state_q;
  logic                busy_q;
  logic                done_q;
  logic [KindW-1:0]    kind_q;
  logic [AmtW-1:0]     amount_q;
  logic [DayW-1:0]     ld_q;
  logic [MonthW-1:0]   lm_q;
  logic [YearW-1:0]    ly_q;
  logic [RemW-1:0]     rem_q;
  logic [YearW-1:0]    x_q;
  logic [CentW-1:0]    qt_q;
  logic [DayW-1:0]     wd_q;
  logic [MonthW-1:0]   wm_q;
  logic [CentW-1:0]    wc_q;
  logic [YyW-1:0]      wyy_q;
  logic [StatW-1:0]    st_q;
  logic                old_leap_q;
  logic                phase_q;
  logic [DayW-1:0]     day_q;
  logic [MonthW-1:0]   month_q;
  logic [YearW-1:0]    year_q;
  logic [DayW-1:0]     out_day_q;
  logic [MonthW-1:0]   out_month_q;
  logic [YearW-1:0]    out_year_q;
  logic [StatW-1:0]    status_q;

  logic                accept;
  logic [ProdW-1:0]    mul_prod;
  logic [CentW-1:0]    quot;
  logic [YearW-1:0]    qt_wide;
  logic [YearW-1:0]    rem100;
  logic [YearW-1:0]    wc_wide;
  logic [YearW-1:0]    year_full;
  logic [RemW-1:0]     amt_wide;
  logic [RemW-1:0]     week_total;
  logic [RemW-1:0]     wd_wide;
  logic                year_zero;
  logic [MonthW-1:0]   pm;
  logic [CentW-1:0]    pc;
  logic [YyW-1:0]      pyy;
  logic                p_leap;
  logic [DayW-1:0]     p_len;
  logic                cur_leap;
  logic [DayW-1:0]     load_len;
  logic                load_bad;

  assign accept = start_i && !busy_q;

  // Shared split unit: quotient by reciprocal, then remainder by shifts and subtraction.
  assign mul_prod = ProdW'(x_q) * ProdW'(RECIP100);
  assign quot     = mul_prod[ProdW-1:RecipShift];
  assign qt_wide  = YearW'(qt_q);
  assign rem100   = x_q - (qt_wide << 6) - (qt_wide << 5) - (qt_wide << 2);

  // Rebuild the full year from the split form: century * 100 + year-in-century.
  assign wc_wide   = YearW'(wc_q);
  assign year_full = (wc_wide << 6) + (wc_wide << 5) + (wc_wide << 2) + YearW'(wyy_q);

  assign amt_wide   = RemW'(amount_i);
  assign week_total = (amt_wide << 3) - amt_wide;
  assign wd_wide    = RemW'(wd_q);

  assign year_zero = (wc_q == '0) && (wyy_q == '0);

  // The month before the working month, with its year and length.
  always_comb begin
    pc  = wc_q;
    pyy = wyy_q;
    if (wm_q == 4'd1) begin
      pm = 4'd12;
      if (wyy_q == '0) begin
        pyy = 7'd99;
        pc  = wc_q - 8'd1;
      end else begin
        pyy = wyy_q - 7'd1;
      end
    end else begin
      pm = wm_q - 4'd1;
    end
  end

  assign p_leap   = is_leap(pc, pyy);
  assign p_len    = month_days(pm, p_leap);
  assign cur_leap = is_leap(wc_q, wyy_q);
  assign load_len = month_days(lm_q, cur_leap);

  // A load is refused for a month outside 1 to 12, a year above 9999, or a
  // day outside the month. A bad month gives a length of zero.
  assign load_bad = (lm_q == 4'd0) || (lm_q > 4'd12) || (ly_q > YEAR_MAX) ||
                    (ld_q == '0) || (ld_q > load_len);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      busy_q      <= 1'b0;
      done_q      <= 1'b0;
      kind_q      <= '0;
      amount_q    <= '0;
      ld_q        <= '0;
      lm_q        <= '0;
      ly_q        <= '0;
      rem_q       <= '0;
      x_q         <= '0;
      qt_q        <= '0;
      wd_q        <= '0;
      wm_q        <= '0;
      wc_q        <= '0;
      wyy_q       <= '0;
      st_q        <= STAT_DONE;
      old_leap_q  <= 1'b0;
      phase_q     <= 1'b0;
      day_q       <= RESET_DAY;
      month_q     <= RESET_MONTH;
      year_q      <= RESET_YEAR;
      out_day_q   <= '0;
      out_month_q <= '0;
      out_year_q  <= '0;
      status_q    <= STAT_DONE;
    end else begin
      // The strobe is high for exactly the cycle after the finishing state.
      done_q <= (state_q == S_FIN);
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            busy_q   <= 1'b1;
            kind_q   <= kind_i;
            amount_q <= amount_i;
            ld_q     <= load_day_i;
            lm_q     <= load_month_i;
            ly_q     <= load_year_i;
            wd_q     <= day_q;
            wm_q     <= month_q;
            phase_q  <= 1'b0;
            // A load splits the new year; every other request splits the held one.
            x_q      <= (kind_i == KIND_LOAD) ? load_year_i : year_q;
            rem_q    <= (kind_i == KIND_WEEKS) ? week_total : amt_wide;
            // Refuse a year request at once when the count reaches past year 0.
            if ((kind_i == KIND_YEARS) && (amount_i > year_q)) begin
              st_q    <= STAT_UNDER;
              state_q <= S_FIN;
            end else begin
              st_q    <= STAT_DONE;
              state_q <= S_MUL;
            end
          end
        end

        S_MUL: begin
          qt_q    <= quot;
          state_q <= S_REM;
        end

        S_REM: begin
          wc_q  <= qt_q;
          wyy_q <= rem100[YyW-1:0];
          case (kind_q)
            KIND_LOAD:               state_q <= S_LOAD;
            KIND_DAYS, KIND_WEEKS:   state_q <= S_DAYS;
            KIND_MONTHS:             state_q <= S_MONS;
            KIND_YEARS:              state_q <= S_YEARS;
            default:                 state_q <= S_FIN;
          endcase
        end

        S_LOAD: begin
          if (load_bad) begin
            st_q <= STAT_BADLOAD;
          end else begin
            wd_q <= ld_q;
            wm_q <= lm_q;
          end
          state_q <= S_FIN;
        end

        // One month boundary per cycle: either the rest fits in the current
        // month, or the whole current day count is consumed and the date
        // moves to the last day of the previous month.
        S_DAYS: begin
          if (rem_q == '0) begin
            state_q <= S_FIN;
          end else if (rem_q < wd_wide) begin
            wd_q  <= wd_q - DayW'(rem_q);
            rem_q <= '0;
          end else if ((wm_q == 4'd1) && year_zero) begin
            st_q    <= STAT_UNDER;
            state_q <= S_FIN;
          end else begin
            rem_q <= rem_q - wd_wide;
            wm_q  <= pm;
            wc_q  <= pc;
            wyy_q <= pyy;
            wd_q  <= p_len;
          end
        end

        // One month per cycle, clamping the day to each month passed.
        S_MONS: begin
          if (rem_q == '0) begin
            state_q <= S_FIN;
          end else if ((wm_q == 4'd1) && year_zero) begin
            st_q    <= STAT_UNDER;
            state_q <= S_FIN;
          end else begin
            rem_q <= rem_q - RemW'(1);
            wm_q  <= pm;
            wc_q  <= pc;
            wyy_q <= pyy;
            if (wd_q > p_len) begin
              wd_q <= p_len;
            end
          end
        end

        // First pass: note whether the old year is a leap year, then split
        // the target year. Second pass: apply the end-of-February rule.
        S_YEARS: begin
          if (!phase_q) begin
            old_leap_q <= cur_leap;
            phase_q    <= 1'b1;
            x_q        <= year_q - amount_q;
            state_q    <= S_MUL;
          end else begin
            if ((wm_q == 4'd2) && (wd_q == (old_leap_q ? 5'd29 : 5'd28))) begin
              wd_q <= month_days(wm_q, cur_leap);
            end
            state_q <= S_FIN;
          end
        end

        S_FIN: begin
          busy_q   <= 1'b0;
          status_q <= st_q;
          state_q  <= S_IDLE;
          if (st_q == STAT_DONE) begin
            day_q       <= wd_q;
            month_q     <= wm_q;
            year_q      <= year_full;
            out_day_q   <= wd_q;
            out_month_q <= wm_q;
            out_year_q  <= year_full;
          end else begin
            out_day_q   <= day_q;
            out_month_q <= month_q;
            out_year_q  <= year_q;
          end
        end

        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign out_day_o   = out_day_q;
  assign out_month_o = out_month_q;
  assign out_year_o  = out_year_q;
  assign status_o    = status_q;

  // An accepted request keeps the core busy in the following cycle.
  `CDD_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o)
  // The done strobe comes with the core already free for the next request.
  `CDD_ASSERT(a_done_free, !done_o || !busy_o)
  // A reported date always has a valid month and a nonzero day.
  `CDD_ASSERT(a_done_date, !done_o || ((|out_month_o) && out_month_o <= 4'd12 && (|out_day_o)))
  // The held year never rises above the largest loadable year.
  `CDD_ASSERT(a_year_range, !done_o || (out_year_o <= 14'd9999))

endmodule
